// File: rtl/oriented_shape_bounding_box_macros.svh
// ----------------------------------------------------------------------------
// oriented_shape_bounding_box_macros
// Assertion helpers shared by the bounding box RTL.
// ----------------------------------------------------------------------------
`ifndef ORIENTED_SHAPE_BOUNDING_BOX_MACROS_SVH
`define ORIENTED_SHAPE_BOUNDING_BOX_MACROS_SVH

// same-cycle implication
`define OSBB_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define OSBB_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/osbb_pkg.sv
// ----------------------------------------------------------------------------
// osbb_pkg
// Types, widths and shape codes for the oriented shape bounding box.
// ----------------------------------------------------------------------------
package osbb_pkg;

  localparam int KIND_W = 3;
  localparam int POS_W  = 32;   // centre, Q16.F
  localparam int SIZE_W = 32;   // sizes, unsigned Q16.F
  localparam int QUAT_W = 16;   // quaternion, Q1.14
  localparam int PROD_W = 32;   // quaternion products, Q.28
  localparam int ENT_W  = 35;   // signed rotation entry working width
  localparam int MAG_W  = 33;   // |entry| <= 2^32
  localparam int MP_W   = 64;   // |entry| * size
  localparam int SC_W   = 36;   // one rounded product term
  localparam int EXT_W  = 47;   // half extent, covers plane at F = 24
  localparam int OUT_W  = 48;   // Q32.F corners

  localparam logic signed [ENT_W-1:0] Q28_ONE = ENT_W'(64'd1 << 28);

  typedef enum logic [KIND_W-1:0] {
    KIND_SPHERE  = 3'd0,
    KIND_BOX     = 3'd1,
    KIND_CAPSULE = 3'd2,
    KIND_PLANE   = 3'd3
  } shape_kind_t;

  typedef logic [2:0][2:0][MAG_W-1:0] mag_mat_t;
  typedef logic [2:0][SIZE_W-1:0]     size_vec_t;
  typedef logic [2:0][POS_W-1:0]      pos_vec_t;
  typedef logic [2:0][EXT_W-1:0]      ext_vec_t;

  // load enables for the two register stages inside a unit
  typedef struct packed {
    logic en_a;
    logic en_b;
  } stage_en_t;

  function automatic logic [MAG_W-1:0] mag_of(input logic signed [ENT_W-1:0] v);
    logic signed [ENT_W-1:0] neg;
    neg = -v;
    return v[ENT_W-1] ? neg[MAG_W-1:0] : v[MAG_W-1:0];
  endfunction

endpackage

// File: rtl/osbb_rot.sv
// ----------------------------------------------------------------------------
// osbb_rot
// Quaternion to absolute rotation matrix, two register stages.
// ----------------------------------------------------------------------------
module osbb_rot import osbb_pkg::*; (
  input  logic                     clk,
  input  stage_en_t                en,
  input  logic signed [QUAT_W-1:0] rot_w,
  input  logic signed [QUAT_W-1:0] rot_x,
  input  logic signed [QUAT_W-1:0] rot_y,
  input  logic signed [QUAT_W-1:0] rot_z,
  output mag_mat_t                 rmag
);

  logic signed [PROD_W-1:0] xx, yy, zz, xy, xz, yz, wx, wy, wz;
  logic signed [ENT_W-1:0]  e [3][3];

  // stage A: the nine products
  always_ff @(posedge clk) begin
    if (en.en_a) begin
      xx <= rot_x * rot_x;
      yy <= rot_y * rot_y;
      zz <= rot_z * rot_z;
      xy <= rot_x * rot_y;
      xz <= rot_x * rot_z;
      yz <= rot_y * rot_z;
      wx <= rot_w * rot_x;
      wy <= rot_w * rot_y;
      wz <= rot_w * rot_z;
    end
  end

  function automatic logic signed [ENT_W-1:0] sx(input logic signed [PROD_W-1:0] v);
    return ENT_W'(v);
  endfunction

  always_comb begin
    e[0][0] = Q28_ONE - ((sx(yy) + sx(zz)) <<< 1);
    e[0][1] = (sx(xy) - sx(wz)) <<< 1;
    e[0][2] = (sx(xz) + sx(wy)) <<< 1;
    e[1][0] = (sx(xy) + sx(wz)) <<< 1;
    e[1][1] = Q28_ONE - ((sx(xx) + sx(zz)) <<< 1);
    e[1][2] = (sx(yz) - sx(wx)) <<< 1;
    e[2][0] = (sx(xz) - sx(wy)) <<< 1;
    e[2][1] = (sx(yz) + sx(wx)) <<< 1;
    e[2][2] = Q28_ONE - ((sx(xx) + sx(yy)) <<< 1);
  end

  // stage B: magnitudes, Q.28, at most 2^32
  always_ff @(posedge clk) begin
    if (en.en_b) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          rmag[i][j] <= mag_of(e[i][j]);
        end
      end
    end
  end

endmodule

// File: rtl/osbb_scale.sv
// ----------------------------------------------------------------------------
// osbb_scale
// Scales |R| by the sizes and selects the half extent per shape kind.
// ----------------------------------------------------------------------------
module osbb_scale import osbb_pkg::*; #(
  parameter int POS_FRAC_BITS = 16
) (
  input  logic              clk,
  input  stage_en_t         en,
  input  mag_mat_t          rmag,
  input  logic [KIND_W-1:0] kind,
  input  size_vec_t         sz,
  output ext_vec_t          ext
);

  localparam logic [EXT_W-1:0] PLANE_EXT = EXT_W'(64'd1000000 << POS_FRAC_BITS);
  localparam logic [EXT_W-1:0] DFLT_EXT  = EXT_W'(((64'd1 << POS_FRAC_BITS) + 64'd5) / 64'd10);

  logic [2:0][2:0][MP_W-1:0] prod;
  logic [KIND_W-1:0]         kind_q;
  logic [SIZE_W-1:0]         sa_q;
  logic [2:0][EXT_W-1:0]     ext_next;

  // stage A: nine products; an entry of exactly 2^32 is a plain shift
  always_ff @(posedge clk) begin
    if (en.en_a) begin
      kind_q <= kind;
      sa_q   <= sz[0];
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          prod[i][j] <= rmag[i][j][MAG_W-1] ? {sz[j], 32'd0}
                                            : rmag[i][j][MAG_W-2:0] * sz[j];
        end
      end
    end
  end

  // round half up back to the position grid
  function automatic logic [SC_W-1:0] rnd28(input logic [MP_W-1:0] p);
    return p[MP_W-1:28] + SC_W'(p[27]);
  endfunction

  function automatic logic [SC_W-2:0] rnd29(input logic [MP_W-1:0] p);
    return p[MP_W-1:29] + (SC_W-1)'(p[28]);
  endfunction

  always_comb begin
    logic [SC_W+1:0] box_sum;
    logic [SC_W:0]   cap_sum;
    for (int i = 0; i < 3; i++) begin
      box_sum = (SC_W+2)'(rnd28(prod[i][0])) + (SC_W+2)'(rnd28(prod[i][1]))
              + (SC_W+2)'(rnd28(prod[i][2]));
      cap_sum = (SC_W+1)'(sa_q) + (SC_W+1)'(rnd29(prod[i][1]));
      case (shape_kind_t'(kind_q))
        KIND_SPHERE:  ext_next[i] = EXT_W'(sa_q);
        KIND_BOX:     ext_next[i] = EXT_W'(box_sum);
        KIND_CAPSULE: ext_next[i] = EXT_W'(cap_sum);
        KIND_PLANE:   ext_next[i] = PLANE_EXT;
        default:      ext_next[i] = DFLT_EXT;
      endcase
    end
  end

  // stage B: half extents
  always_ff @(posedge clk) begin
    if (en.en_b) begin
      ext <= ext_next;
    end
  end

endmodule

// File: rtl/oriented_shape_bounding_box.sv
// ----------------------------------------------------------------------------
// oriented_shape_bounding_box
// World axis-aligned box around one oriented sphere, box, capsule or plane.
// ----------------------------------------------------------------------------
// Input channel: in_valid / in_stall with shape_kind, centre, rotation
// quaternion and sizes. Output channel: out_valid / out_stall with the low
// and high corners (Q32.F). A beat moves when valid is high and stall low.
// Five register stages: quaternion products, |R| entries, |R| * size
// products, rounded per-axis half extent, then centre -/+ extent into the
// output register. One beat per cycle is taken while out_stall stays low.
// Each stage loads whenever it is empty or the stage after it moves, so
// bubbles close up and in_stall only rises once the pipeline is full behind
// a stalled output. A stalled output beat holds its value until taken.
// Reset (synchronous) clears all valid bits; payload registers are not reset.
// No state is carried between beats.
// ----------------------------------------------------------------------------
`include "oriented_shape_bounding_box_macros.svh"

module oriented_shape_bounding_box import osbb_pkg::*; #(
  parameter int POS_FRAC_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [KIND_W-1:0]        shape_kind,
  input  logic signed [POS_W-1:0]  centre_x,
  input  logic signed [POS_W-1:0]  centre_y,
  input  logic signed [POS_W-1:0]  centre_z,
  input  logic signed [QUAT_W-1:0] rot_w,
  input  logic signed [QUAT_W-1:0] rot_x,
  input  logic signed [QUAT_W-1:0] rot_y,
  input  logic signed [QUAT_W-1:0] rot_z,
  input  logic [SIZE_W-1:0]        size_a,
  input  logic [SIZE_W-1:0]        size_b,
  input  logic [SIZE_W-1:0]        size_c,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [OUT_W-1:0]  low_x,
  output logic signed [OUT_W-1:0]  low_y,
  output logic signed [OUT_W-1:0]  low_z,
  output logic signed [OUT_W-1:0]  high_x,
  output logic signed [OUT_W-1:0]  high_y,
  output logic signed [OUT_W-1:0]  high_z
);

  logic v1, v2, v3, v4, v5;
  logic en1, en2, en3, en4, en5;

  stage_en_t rot_en, scl_en;

  logic [KIND_W-1:0] kind1, kind2;
  pos_vec_t          cen1, cen2, cen3, cen4;
  size_vec_t         sz1, sz2;
  mag_mat_t          rmag;
  ext_vec_t          ext;

  logic [2:0][OUT_W-1:0] lo_next, hi_next;

  // stage loads ripple back from the output
  assign en5 = !v5 || !out_stall;
  assign en4 = !v4 || en5;
  assign en3 = !v3 || en4;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;

  assign in_stall  = !en1;
  assign out_valid = v5;

  assign rot_en = '{en_a: en1, en_b: en2};
  assign scl_en = '{en_a: en3, en_b: en4};

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      if (en1) v1 <= in_valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) v4 <= v3;
      if (en5) v5 <= v4;
    end
  end

  // side data riding alongside the math units
  always_ff @(posedge clk) begin
    if (en1) begin
      kind1 <= shape_kind;
      cen1  <= {centre_z, centre_y, centre_x};
      sz1   <= {size_c, size_b, size_a};
    end
    if (en2) begin
      kind2 <= kind1;
      cen2  <= cen1;
      sz2   <= sz1;
    end
    if (en3) cen3 <= cen2;
    if (en4) cen4 <= cen3;
  end

  osbb_rot u_rot (
    .clk   (clk),
    .en    (rot_en),
    .rot_w (rot_w),
    .rot_x (rot_x),
    .rot_y (rot_y),
    .rot_z (rot_z),
    .rmag  (rmag)
  );

  osbb_scale #(
    .POS_FRAC_BITS (POS_FRAC_BITS)
  ) u_scale (
    .clk  (clk),
    .en   (scl_en),
    .rmag (rmag),
    .kind (kind2),
    .sz   (sz2),
    .ext  (ext)
  );

  always_comb begin
    logic [OUT_W-1:0] c_w, h_w;
    for (int i = 0; i < 3; i++) begin
      c_w        = {{(OUT_W-POS_W){cen4[i][POS_W-1]}}, cen4[i]};
      h_w        = {1'b0, ext[i]};
      lo_next[i] = c_w - h_w;
      hi_next[i] = c_w + h_w;
    end
  end

  always_ff @(posedge clk) begin
    if (en5) begin
      low_x  <= lo_next[0];
      low_y  <= lo_next[1];
      low_z  <= lo_next[2];
      high_x <= hi_next[0];
      high_y <= hi_next[1];
      high_z <= hi_next[2];
    end
  end

  `OSBB_ASSERT_NOW(a_stall_needs_full, clk, rst, in_stall, v1, "input stalled with empty first stage")
  `OSBB_ASSERT_NEXT(a_drain, clk, rst, out_valid && !out_stall && !v4, !out_valid, "output beat repeated")
  `OSBB_ASSERT_NOW(a_order_x, clk, rst, out_valid, $signed(low_x) <= $signed(high_x), "low_x above high_x")
  `OSBB_ASSERT_NOW(a_order_yz, clk, rst, out_valid, ($signed(low_y) <= $signed(high_y)) && ($signed(low_z) <= $signed(high_z)), "low above high on y or z")

endmodule

// File: sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Bounding box checks for oriented_shape_bounding_box.
// Sends bodies of every shape kind through the valid/stall input and
// predicts each min/max corner pair in fixed point. A small scoreboard
// compares every output beat in order. Directed corner cases come first,
// then random bodies, mostly with unit quaternions. Random idle bursts are
// applied on both sides, plus one long output hold and one full drain.
// ----------------------------------------------------------------------------
module tb_top;
  import osbb_pkg::*;

  localparam int FRAC         = 16;
  localparam logic [QUAT_W-1:0] QONE = 16'd16384;   // 1.0 in Q1.14
  localparam int N_RANDOM     = 800;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_AT     = 450;
  localparam int HOLD_AT      = 200;
  localparam int QUIET_AT     = 650;
  localparam logic [63:0] PLANE_EXT   = 64'd1000000 << FRAC;
  localparam logic [63:0] DEFAULT_EXT = ((64'd1 << FRAC) + 64'd5) / 64'd10;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [POS_W-1:0]  cx, cy, cz;
    logic [QUAT_W-1:0] qw, qx, qy, qz;
    logic [SIZE_W-1:0] sa, sb, sc;
  } body_t;

  typedef struct packed {
    logic [2:0][OUT_W-1:0] lo;
    logic [2:0][OUT_W-1:0] hi;
  } corners_t;

  class box_scoreboard;
    corners_t want_q[$];
    int       mismatches = 0;

    // |entry| (Q.28) times an unsigned size, rounded half up by sh bits
    function logic [63:0] scaled_term(logic signed [63:0] ent, logic [31:0] v, int sh);
      logic [65:0] m;
      logic [65:0] p;
      m = (ent < 0) ? 66'(-ent) : 66'(ent);
      p = m * 66'(v);
      return 64'((p + (66'd1 << (sh - 1))) >> sh);
    endfunction

    function corners_t predict_bounds(body_t b);
      logic signed [63:0] w, x, y, z;
      logic signed [63:0] r [3][3];
      logic signed [63:0] ctr [3];
      logic [63:0]        half;
      corners_t           res;
      w = $signed(b.qw);
      x = $signed(b.qx);
      y = $signed(b.qy);
      z = $signed(b.qz);
      ctr[0] = $signed(b.cx);
      ctr[1] = $signed(b.cy);
      ctr[2] = $signed(b.cz);
      r[0][0] = (64'sd1 <<< 28) - 2 * (y * y + z * z);
      r[0][1] = 2 * (x * y - w * z);
      r[0][2] = 2 * (x * z + w * y);
      r[1][0] = 2 * (x * y + w * z);
      r[1][1] = (64'sd1 <<< 28) - 2 * (x * x + z * z);
      r[1][2] = 2 * (y * z - w * x);
      r[2][0] = 2 * (x * z - w * y);
      r[2][1] = 2 * (y * z + w * x);
      r[2][2] = (64'sd1 <<< 28) - 2 * (x * x + y * y);
      for (int i = 0; i < 3; i++) begin
        case (b.kind)
          KIND_SPHERE: begin
            half = 64'(b.sa);
          end
          KIND_BOX: begin
            half = scaled_term(r[i][0], b.sa, 28) + scaled_term(r[i][1], b.sb, 28)
                 + scaled_term(r[i][2], b.sc, 28);
          end
          KIND_CAPSULE: begin
            // half height: one extra bit of shift
            half = 64'(b.sa) + scaled_term(r[i][1], b.sb, 29);
          end
          KIND_PLANE: begin
            half = PLANE_EXT;
          end
          default: begin
            half = DEFAULT_EXT;
          end
        endcase
        res.lo[i] = OUT_W'(ctr[i] - half);
        res.hi[i] = OUT_W'(ctr[i] + half);
      end
      return res;
    endfunction

    function void note_body(body_t b);
      want_q.push_back(predict_bounds(b));
    endfunction

    function void check_corners(corners_t got);
      corners_t want;
      if (want_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: output beat with nothing pending: lo=%h hi=%h",
                   $realtime, got.lo, got.hi);
        return;
      end
      want = want_q.pop_front();
      for (int i = 0; i < 3; i++) begin
        if (got.lo[i] !== want.lo[i]) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: low axis %0d mismatch: expected %h, got %h",
                     $realtime, i, want.lo[i], got.lo[i]);
        end
        if (got.hi[i] !== want.hi[i]) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: high axis %0d mismatch: expected %h, got %h",
                     $realtime, i, want.hi[i], got.hi[i]);
        end
      end
    endfunction

    function int pending();
      return want_q.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                     in_valid   = 1'b0;
  logic                     in_stall;
  logic [KIND_W-1:0]        shape_kind = '0;
  logic signed [POS_W-1:0]  centre_x   = '0;
  logic signed [POS_W-1:0]  centre_y   = '0;
  logic signed [POS_W-1:0]  centre_z   = '0;
  logic signed [QUAT_W-1:0] rot_w      = '0;
  logic signed [QUAT_W-1:0] rot_x      = '0;
  logic signed [QUAT_W-1:0] rot_y      = '0;
  logic signed [QUAT_W-1:0] rot_z      = '0;
  logic [SIZE_W-1:0]        size_a     = '0;
  logic [SIZE_W-1:0]        size_b     = '0;
  logic [SIZE_W-1:0]        size_c     = '0;
  logic                     out_valid;
  logic                     out_stall  = 1'b0;
  logic signed [OUT_W-1:0]  low_x, low_y, low_z;
  logic signed [OUT_W-1:0]  high_x, high_y, high_z;

  box_scoreboard sb = new();

  bit quiet      = 1'b0;   // no idling on either side
  int hold_token = 0;      // bumped to request one long output hold
  int hold_seen  = 0;
  int hold_run   = 0;
  int stall_run  = 0;

  oriented_shape_bounding_box #(.POS_FRAC_BITS(FRAC)) u_top (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .shape_kind (shape_kind),
    .centre_x   (centre_x),
    .centre_y   (centre_y),
    .centre_z   (centre_z),
    .rot_w      (rot_w),
    .rot_x      (rot_x),
    .rot_y      (rot_y),
    .rot_z      (rot_z),
    .size_a     (size_a),
    .size_b     (size_b),
    .size_c     (size_c),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .low_x      (low_x),
    .low_y      (low_y),
    .low_z      (low_z),
    .high_x     (high_x),
    .high_y     (high_y),
    .high_z     (high_z)
  );

  always #5 clk = ~clk;

  // receiver: check accepted beats, then pick stall for the next cycle
  always @(posedge clk) begin
    corners_t got;
    if (out_valid && !out_stall) begin
      got.lo = {low_z, low_y, low_x};
      got.hi = {high_z, high_y, high_x};
      sb.check_corners(got);
    end
    if (hold_token != hold_seen) begin
      hold_seen = hold_token;
      hold_run  = HOLD_CYCLES;
    end
    if (hold_run > 0) begin
      hold_run--;
      out_stall <= 1'b1;
    end else if (stall_run > 0) begin
      stall_run--;
      out_stall <= 1'b1;
    end else if (!quiet && $urandom_range(0, 9) == 0) begin
      stall_run = $urandom_range(0, 15);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  function automatic body_t mk_body(logic [KIND_W-1:0] k,
                                    logic [31:0] cx, logic [31:0] cy, logic [31:0] cz,
                                    logic [15:0] qw, logic [15:0] qx,
                                    logic [15:0] qy, logic [15:0] qz,
                                    logic [31:0] a, logic [31:0] b, logic [31:0] c);
    body_t t;
    t.kind = k;
    t.cx = cx; t.cy = cy; t.cz = cz;
    t.qw = qw; t.qx = qx; t.qy = qy; t.qz = qz;
    t.sa = a;  t.sb = b;  t.sc = c;
    return t;
  endfunction

  function automatic logic [31:0] rand_size();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 4) return $urandom;
    if (sel < 8) return $urandom_range(0, 32'h0040_0000);
    if (sel == 8) return 32'hFFFF_FFFF;
    return 32'h0;
  endfunction

  function automatic body_t rand_body();
    body_t t;
    int    sel;
    real   q [4];
    real   norm;
    sel = $urandom_range(0, 11);
    if (sel < 2)       t.kind = KIND_SPHERE;
    else if (sel < 6)  t.kind = KIND_BOX;
    else if (sel < 9)  t.kind = KIND_CAPSULE;
    else if (sel < 10) t.kind = KIND_PLANE;
    else               t.kind = KIND_W'($urandom_range(4, 7));
    t.cx = $urandom;
    t.cy = $urandom;
    t.cz = $urandom;
    if ($urandom_range(0, 4) != 0) begin
      // unit quaternion from a random direction in 4D
      for (int i = 0; i < 4; i++)
        q[i] = real'(int'($urandom_range(0, 65536)) - 32768);
      norm = $sqrt(q[0] * q[0] + q[1] * q[1] + q[2] * q[2] + q[3] * q[3]);
      if (norm < 1.0) begin
        q[0] = 1.0; q[1] = 0.0; q[2] = 0.0; q[3] = 0.0;
        norm = 1.0;
      end
      t.qw = 16'($rtoi(q[0] / norm * QONE));
      t.qx = 16'($rtoi(q[1] / norm * QONE));
      t.qy = 16'($rtoi(q[2] / norm * QONE));
      t.qz = 16'($rtoi(q[3] / norm * QONE));
    end else begin
      t.qw = 16'($urandom);
      t.qx = 16'($urandom);
      t.qy = 16'($urandom);
      t.qz = 16'($urandom);
    end
    t.sa = rand_size();
    t.sb = rand_size();
    t.sc = rand_size();
    return t;
  endfunction

  task automatic send_body(input body_t b);
    int gap;
    if (!quiet && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      gap = $urandom_range(1, 16);
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    shape_kind <= b.kind;
    centre_x   <= b.cx;
    centre_y   <= b.cy;
    centre_z   <= b.cz;
    rot_w      <= b.qw;
    rot_x      <= b.qx;
    rot_y      <= b.qy;
    rot_z      <= b.qz;
    size_a     <= b.sa;
    size_b     <= b.sb;
    size_c     <= b.sc;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_body(b);
  endtask

  initial begin
    body_t dir_q[$];
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // spheres: zero radius, max radius at both centre extremes, unused sizes set
    dir_q.push_back(mk_body(KIND_SPHERE, 0, 0, 0, QONE, 0, 0, 0, 0, 0, 0));
    dir_q.push_back(mk_body(KIND_SPHERE, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                            QONE, 0, 0, 0, 32'hFFFF_FFFF, 32'h1234_5678, 32'hFFFF_FFFF));
    dir_q.push_back(mk_body(KIND_SPHERE, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                            16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF,
                            32'hFFFF_FFFF, 0, 0));
    // boxes
    dir_q.push_back(mk_body(KIND_BOX, 32'h0001_0000, 32'hFFFE_0000, 0, QONE, 0, 0, 0,
                            32'h0001_0000, 32'h0002_0000, 32'h0003_0000));
    dir_q.push_back(mk_body(KIND_BOX, 0, 0, 0, QONE, 0, 0, 0,
                            32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    dir_q.push_back(mk_body(KIND_BOX, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                            16'h8000, 16'h8000, 16'h8000, 16'h8000,
                            32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    dir_q.push_back(mk_body(KIND_BOX, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                            16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF,
                            32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    dir_q.push_back(mk_body(KIND_BOX, 0, 0, 0, 16'd11585, 0, 0, 16'd11585,
                            32'h0004_0000, 32'h0001_0000, 32'h0000_8000));
    dir_q.push_back(mk_body(KIND_BOX, 32'h0000_0001, 32'hFFFF_FFFF, 0, 0, 0, 0, 0,
                            32'h0010_0000, 32'h0020_0000, 32'h0030_0000));
    dir_q.push_back(mk_body(KIND_BOX, 0, 0, 0, 16'h8000, 16'h7FFF, 16'h0001, 16'hFFFF,
                            32'h0000_0001, 32'h0000_0003, 32'hFFFF_FFFF));
    // capsules
    dir_q.push_back(mk_body(KIND_CAPSULE, 0, 0, 0, QONE, 0, 0, 0,
                            32'h0000_8000, 32'h0002_0000, 0));
    dir_q.push_back(mk_body(KIND_CAPSULE, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                            0, 16'h7FFF, 0, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0));
    dir_q.push_back(mk_body(KIND_CAPSULE, 0, 0, 0, 16'd11585, 16'd11585, 0, 0,
                            32'h0001_0000, 32'h0004_0000, 32'hFFFF_FFFF));
    dir_q.push_back(mk_body(KIND_CAPSULE, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                            16'h8000, 16'h8000, 16'h7FFF, 16'h8000,
                            32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    // planes
    dir_q.push_back(mk_body(KIND_PLANE, 0, 0, 0, QONE, 0, 0, 0, 0, 0, 0));
    dir_q.push_back(mk_body(KIND_PLANE, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                            16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000,
                            32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    dir_q.push_back(mk_body(KIND_PLANE, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                            QONE, 0, 0, 0, 32'h0001_0000, 0, 0));
    // unknown kinds fall to the small default extent
    dir_q.push_back(mk_body(3'd4, 0, 0, 0, QONE, 0, 0, 0,
                            32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    dir_q.push_back(mk_body(3'd5, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                            16'h8000, 16'h8000, 16'h8000, 16'h8000, 0, 0, 0));
    dir_q.push_back(mk_body(3'd6, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                            16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 32'h5555_5555,
                            32'hAAAA_AAAA, 32'h5555_5555));
    dir_q.push_back(mk_body(3'd7, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0001,
                            0, 0, 0, 0, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA));

    foreach (dir_q[i]) send_body(dir_q[i]);

    for (int n = 0; n < N_RANDOM; n++) begin
      // long output hold while input keeps coming: pipeline fills, input stalls
      if (n == HOLD_AT) hold_token++;
      if (n == DRAIN_AT) begin
        // last beat was just taken; drop valid so it is not sent twice
        in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
      end
      if (n == QUIET_AT) quiet = 1'b1;
      send_body(rand_body());
    end
    in_valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

// File: filelist.f
+incdir+rtl
rtl/osbb_pkg.sv
rtl/osbb_rot.sv
rtl/osbb_scale.sv
rtl/oriented_shape_bounding_box.sv
sim/tb_top.sv
